// File: sv/dac_pkg.sv
// ----------------------------------------------------------------------------
// dac_pkg
// Shared widths, codes, types and the command decoder of the dual
// accumulator compare unit.
// ----------------------------------------------------------------------------
package dac_pkg;

    // Default accumulator width.
    localparam int DAC_DATA_WIDTH = 32;

    // Fixed field widths of the channels.
    localparam int OPCODE_W    = 5;
    localparam int OPERAND_W   = 32;
    localparam int KIND_W      = 2;
    localparam int REPORT_W    = 32;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int ACTION_W    = 4;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_INIT_LEFT      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_INIT_RIGHT     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_COMPARE_ACTION = 2'd2;

    // On-compare actions.
    localparam logic [ACTION_W-1:0] ACT_CLEAR_BOTH    = 4'd0;
    localparam logic [ACTION_W-1:0] ACT_CLEAR_LEFT    = 4'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR_RIGHT   = 4'd2;
    localparam logic [ACTION_W-1:0] ACT_RESTORE_BOTH  = 4'd3;
    localparam logic [ACTION_W-1:0] ACT_RESTORE_LEFT  = 4'd4;
    localparam logic [ACTION_W-1:0] ACT_RESTORE_RIGHT = 4'd5;
    localparam logic [ACTION_W-1:0] ACT_COPY_L2R      = 4'd6;
    localparam logic [ACTION_W-1:0] ACT_COPY_R2L      = 4'd7;
    localparam logic [ACTION_W-1:0] ACT_NONE          = 4'd8;

    // Report kinds.
    localparam logic [KIND_W-1:0] RK_EQUAL     = 2'd0;
    localparam logic [KIND_W-1:0] RK_NOT_EQUAL = 2'd1;
    localparam logic [KIND_W-1:0] RK_COMPARED  = 2'd2;

    // Command opcodes.
    localparam logic [OPCODE_W-1:0] OP_COMPARE          = 5'd0;
    localparam logic [OPCODE_W-1:0] OP_SET_BOTH         = 5'd1;
    localparam logic [OPCODE_W-1:0] OP_SET_LEFT         = 5'd2;
    localparam logic [OPCODE_W-1:0] OP_SET_RIGHT        = 5'd3;
    localparam logic [OPCODE_W-1:0] OP_SET_LEFT_CMP     = 5'd4;
    localparam logic [OPCODE_W-1:0] OP_SET_RIGHT_CMP    = 5'd5;
    localparam logic [OPCODE_W-1:0] OP_ADD_BOTH         = 5'd6;
    localparam logic [OPCODE_W-1:0] OP_ADD_LEFT         = 5'd7;
    localparam logic [OPCODE_W-1:0] OP_ADD_RIGHT        = 5'd8;
    localparam logic [OPCODE_W-1:0] OP_ADD_LEFT_CMP     = 5'd9;
    localparam logic [OPCODE_W-1:0] OP_ADD_RIGHT_CMP    = 5'd10;
    localparam logic [OPCODE_W-1:0] OP_MUL_BOTH         = 5'd11;
    localparam logic [OPCODE_W-1:0] OP_MUL_LEFT         = 5'd12;
    localparam logic [OPCODE_W-1:0] OP_MUL_RIGHT        = 5'd13;
    localparam logic [OPCODE_W-1:0] OP_MUL_LEFT_CMP     = 5'd14;
    localparam logic [OPCODE_W-1:0] OP_MUL_RIGHT_CMP    = 5'd15;
    localparam logic [OPCODE_W-1:0] OP_DIV_BOTH         = 5'd16;
    localparam logic [OPCODE_W-1:0] OP_DIV_LEFT         = 5'd17;
    localparam logic [OPCODE_W-1:0] OP_DIV_RIGHT        = 5'd18;
    localparam logic [OPCODE_W-1:0] OP_DIV_LEFT_CMP     = 5'd19;
    localparam logic [OPCODE_W-1:0] OP_DIV_RIGHT_CMP    = 5'd20;
    localparam logic [OPCODE_W-1:0] OP_CLEAR_BOTH       = 5'd21;
    localparam logic [OPCODE_W-1:0] OP_CLEAR_LEFT       = 5'd22;
    localparam logic [OPCODE_W-1:0] OP_CLEAR_RIGHT      = 5'd23;
    localparam logic [OPCODE_W-1:0] OP_RESTORE_BOTH     = 5'd24;
    localparam logic [OPCODE_W-1:0] OP_RESTORE_LEFT     = 5'd25;
    localparam logic [OPCODE_W-1:0] OP_RESTORE_RIGHT    = 5'd26;

    // Kind of update that a command applies to an accumulator.
    typedef enum logic [2:0] {
        KIND_SET,
        KIND_ADD,
        KIND_MUL,
        KIND_DIV,
        KIND_CLEAR,
        KIND_RESTORE
    } cmd_kind_t;

    // Decoded command.
    typedef struct packed {
        logic      valid;
        cmd_kind_t kind;
        logic      upd_left;
        logic      upd_right;
        logic      cmp;
    } cmd_dec_t;

    // Serial unit operations.
    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_DIV
    } alu_op_t;

    // Request from the sequencer to the serial unit.
    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_ctl_t;

    // Configuration register contents.
    typedef struct packed {
        logic signed [CFG_DATA_W-1:0] init_left;
        logic signed [CFG_DATA_W-1:0] init_right;
        logic        [ACTION_W-1:0]   action;
    } cfg_t;

    // Build one decoded command.
    function automatic cmd_dec_t dac_mk(cmd_kind_t kind, logic l, logic r, logic c);
        cmd_dec_t d;
        d.valid     = 1'b1;
        d.kind      = kind;
        d.upd_left  = l;
        d.upd_right = r;
        d.cmp       = c;
        return d;
    endfunction

    // Decode an opcode; commands not from an event or with unused codes are dropped.
    function automatic cmd_dec_t dac_decode(logic [OPCODE_W-1:0] opcode, logic from_event);
        cmd_dec_t d;
        case (opcode)
            OP_COMPARE:       d = dac_mk(KIND_SET,     1'b0, 1'b0, 1'b1);
            OP_SET_BOTH:      d = dac_mk(KIND_SET,     1'b1, 1'b1, 1'b0);
            OP_SET_LEFT:      d = dac_mk(KIND_SET,     1'b1, 1'b0, 1'b0);
            OP_SET_RIGHT:     d = dac_mk(KIND_SET,     1'b0, 1'b1, 1'b0);
            OP_SET_LEFT_CMP:  d = dac_mk(KIND_SET,     1'b1, 1'b0, 1'b1);
            OP_SET_RIGHT_CMP: d = dac_mk(KIND_SET,     1'b0, 1'b1, 1'b1);
            OP_ADD_BOTH:      d = dac_mk(KIND_ADD,     1'b1, 1'b1, 1'b0);
            OP_ADD_LEFT:      d = dac_mk(KIND_ADD,     1'b1, 1'b0, 1'b0);
            OP_ADD_RIGHT:     d = dac_mk(KIND_ADD,     1'b0, 1'b1, 1'b0);
            OP_ADD_LEFT_CMP:  d = dac_mk(KIND_ADD,     1'b1, 1'b0, 1'b1);
            OP_ADD_RIGHT_CMP: d = dac_mk(KIND_ADD,     1'b0, 1'b1, 1'b1);
            OP_MUL_BOTH:      d = dac_mk(KIND_MUL,     1'b1, 1'b1, 1'b0);
            OP_MUL_LEFT:      d = dac_mk(KIND_MUL,     1'b1, 1'b0, 1'b0);
            OP_MUL_RIGHT:     d = dac_mk(KIND_MUL,     1'b0, 1'b1, 1'b0);
            OP_MUL_LEFT_CMP:  d = dac_mk(KIND_MUL,     1'b1, 1'b0, 1'b1);
            OP_MUL_RIGHT_CMP: d = dac_mk(KIND_MUL,     1'b0, 1'b1, 1'b1);
            OP_DIV_BOTH:      d = dac_mk(KIND_DIV,     1'b1, 1'b1, 1'b0);
            OP_DIV_LEFT:      d = dac_mk(KIND_DIV,     1'b1, 1'b0, 1'b0);
            OP_DIV_RIGHT:     d = dac_mk(KIND_DIV,     1'b0, 1'b1, 1'b0);
            OP_DIV_LEFT_CMP:  d = dac_mk(KIND_DIV,     1'b1, 1'b0, 1'b1);
            OP_DIV_RIGHT_CMP: d = dac_mk(KIND_DIV,     1'b0, 1'b1, 1'b1);
            OP_CLEAR_BOTH:    d = dac_mk(KIND_CLEAR,   1'b1, 1'b1, 1'b0);
            OP_CLEAR_LEFT:    d = dac_mk(KIND_CLEAR,   1'b1, 1'b0, 1'b0);
            OP_CLEAR_RIGHT:   d = dac_mk(KIND_CLEAR,   1'b0, 1'b1, 1'b0);
            OP_RESTORE_BOTH:  d = dac_mk(KIND_RESTORE, 1'b1, 1'b1, 1'b0);
            OP_RESTORE_LEFT:  d = dac_mk(KIND_RESTORE, 1'b1, 1'b0, 1'b0);
            OP_RESTORE_RIGHT: d = dac_mk(KIND_RESTORE, 1'b0, 1'b1, 1'b0);
            default:
            begin
                d       = dac_mk(KIND_SET, 1'b0, 1'b0, 1'b0);
                d.valid = 1'b0;
            end
        endcase
        if (!from_event)
        begin
            d.valid = 1'b0;
        end
        return d;
    endfunction

endpackage

// File: sv/dac_cfg_if.sv
// ----------------------------------------------------------------------------
// dac_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface dac_cfg_if import dac_pkg::*; ();

    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);

endinterface

// File: sv/dac_cmd_if.sv
// ----------------------------------------------------------------------------
// dac_cmd_if
// Command channel: one item is one accumulator command.
// ----------------------------------------------------------------------------
interface dac_cmd_if import dac_pkg::*; ();

    logic                        valid;
    logic                        ready;
    logic        [OPCODE_W-1:0]  opcode;
    logic signed [OPERAND_W-1:0] operand;
    logic                        from_event;

    modport source (output valid, output opcode, output operand, output from_event,
                    input ready);
    modport sink   (input valid, input opcode, input operand, input from_event,
                    output ready);

endinterface

// File: sv/dac_rpt_if.sv
// ----------------------------------------------------------------------------
// dac_rpt_if
// Report channel: one item is one compare result.
// ----------------------------------------------------------------------------
interface dac_rpt_if import dac_pkg::*; ();

    logic                       valid;
    logic                       ready;
    logic        [KIND_W-1:0]   report_kind;
    logic signed [REPORT_W-1:0] report_value;
    logic                       last;

    modport source (output valid, output report_kind, output report_value, output last,
                    input ready);
    modport sink   (input valid, input report_kind, input report_value, input last,
                    output ready);

endinterface

// File: sv/dac_serial_alu.sv
// ----------------------------------------------------------------------------
// dac_serial_alu
// Shared iterative arithmetic unit, one bit per cycle: bit-serial add and
// subtract, shift-add multiply, restoring signed divide.
// ----------------------------------------------------------------------------
module dac_serial_alu
    import dac_pkg::*;
#(
    parameter int DATA_WIDTH = DAC_DATA_WIDTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  alu_ctl_t              ctl,
    input  logic [DATA_WIDTH-1:0] a,
    input  logic [DATA_WIDTH-1:0] b,
    output logic                  done,
    output logic [DATA_WIDTH-1:0] result
);

    localparam int CNT_W = $clog2(DATA_WIDTH);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_PREP = 5'b00010,
        ST_RUN  = 5'b00100,
        ST_FIX  = 5'b01000,
        ST_DONE = 5'b10000
    } alu_state_t;

    alu_state_t            state_reg, state_next;
    alu_op_t               op_reg, op_next;
    logic [DATA_WIDTH-1:0] opa_reg, opa_next;
    logic [DATA_WIDTH-1:0] opb_reg, opb_next;
    logic [DATA_WIDTH:0]   acc_reg, acc_next;
    logic                  carry_reg, carry_next;
    logic                  neg_reg, neg_next;
    logic                  zero_reg, zero_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;

    logic                  sum_bit;
    logic                  sum_carry;
    logic [DATA_WIDTH:0]   rem_sh;
    logic [DATA_WIDTH:0]   rem_diff;
    logic [DATA_WIDTH-1:0] mul_sum;

    // Per-cycle datapath: one sum bit, one partial product, one quotient bit.
    assign sum_bit   = opa_reg[0] ^ opb_reg[0] ^ carry_reg;
    assign sum_carry = (opa_reg[0] & opb_reg[0]) | (carry_reg & (opa_reg[0] ^ opb_reg[0]));
    assign rem_sh    = {acc_reg[DATA_WIDTH-1:0], opa_reg[DATA_WIDTH-1]};
    assign rem_diff  = rem_sh - {1'b0, opb_reg};
    assign mul_sum   = acc_reg[DATA_WIDTH-1:0] + (opb_reg[0] ? opa_reg : '0);

    // Sequencing of one operation.
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        opa_next   = opa_reg;
        opb_next   = opb_reg;
        acc_next   = acc_reg;
        carry_next = carry_reg;
        neg_next   = neg_reg;
        zero_next  = zero_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (ctl.start)
                begin
                    op_next    = ctl.op;
                    opa_next   = a;
                    opb_next   = b;
                    acc_next   = '0;
                    carry_next = 1'b0;
                    cnt_next   = '0;
                    state_next = ST_RUN;
                    if (ctl.op == ALU_SUB)
                    begin
                        opb_next   = ~b;
                        carry_next = 1'b1;
                    end
                    if (ctl.op == ALU_DIV)
                    begin
                        state_next = ST_PREP;
                    end
                end
            end
            ST_PREP:
            begin
                // Divide works on magnitudes; the sign is put back at the end.
                neg_next   = opa_reg[DATA_WIDTH-1] ^ opb_reg[DATA_WIDTH-1];
                zero_next  = (opb_reg == '0);
                opa_next   = opa_reg[DATA_WIDTH-1] ? (~opa_reg + 1'b1) : opa_reg;
                opb_next   = opb_reg[DATA_WIDTH-1] ? (~opb_reg + 1'b1) : opb_reg;
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                case (op_reg)
                    ALU_ADD, ALU_SUB:
                    begin
                        opa_next   = {sum_bit, opa_reg[DATA_WIDTH-1:1]};
                        opb_next   = {1'b0, opb_reg[DATA_WIDTH-1:1]};
                        carry_next = sum_carry;
                    end
                    ALU_MUL:
                    begin
                        acc_next = {1'b0, mul_sum};
                        opa_next = {opa_reg[DATA_WIDTH-2:0], 1'b0};
                        opb_next = {1'b0, opb_reg[DATA_WIDTH-1:1]};
                    end
                    default:
                    begin
                        if (!rem_diff[DATA_WIDTH])
                        begin
                            acc_next = rem_diff;
                            opa_next = {opa_reg[DATA_WIDTH-2:0], 1'b1};
                        end
                        else
                        begin
                            acc_next = rem_sh;
                            opa_next = {opa_reg[DATA_WIDTH-2:0], 1'b0};
                        end
                    end
                endcase
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DATA_WIDTH - 1))
                begin
                    state_next = (op_reg == ALU_DIV) ? ST_FIX : ST_DONE;
                end
            end
            ST_FIX:
            begin
                // Division by zero gives zero; otherwise restore the sign.
                if (zero_reg)
                begin
                    opa_next = '0;
                end
                else if (neg_reg)
                begin
                    opa_next = ~opa_reg + 1'b1;
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Datapath shift registers.
    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        opa_reg   <= opa_next;
        opb_reg   <= opb_next;
        acc_reg   <= acc_next;
        carry_reg <= carry_next;
        neg_reg   <= neg_next;
        zero_reg  <= zero_next;
    end

    assign done   = (state_reg == ST_DONE);
    assign result = (op_reg == ALU_MUL) ? acc_reg[DATA_WIDTH-1:0] : opa_reg;

endmodule

// File: sv/dac_ctrl.sv
// ----------------------------------------------------------------------------
// dac_ctrl
// Command sequencer: holds both accumulators, drives the serial unit for
// each add, multiply or divide and the compare, runs the on-compare action
// and issues the two report items.
// ----------------------------------------------------------------------------
module dac_ctrl
    import dac_pkg::*;
#(
    parameter int DATA_WIDTH = DAC_DATA_WIDTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    dac_cmd_if.sink   cmd,
    dac_rpt_if.source rpt
);

    typedef enum logic [8:0] {
        C_IDLE  = 9'b000000001,
        C_LEFT  = 9'b000000010,
        C_LWAIT = 9'b000000100,
        C_RIGHT = 9'b000001000,
        C_RWAIT = 9'b000010000,
        C_CMP   = 9'b000100000,
        C_CWAIT = 9'b001000000,
        C_OUT1  = 9'b010000000,
        C_OUT2  = 9'b100000000
    } ctrl_state_t;

    ctrl_state_t           state_reg, state_next;
    cmd_dec_t              dec_reg, dec_next;
    logic [DATA_WIDTH-1:0] operand_reg, operand_next;
    logic [DATA_WIDTH-1:0] left_reg, left_next;
    logic [DATA_WIDTH-1:0] right_reg, right_next;
    logic [DATA_WIDTH-1:0] diff_reg, diff_next;
    logic [KIND_W-1:0]     kind_reg, kind_next;
    logic [REPORT_W-1:0]   value_reg, value_next;
    logic                  last_reg, last_next;

    cmd_dec_t              dec_in;
    logic [DATA_WIDTH-1:0] init_left_w;
    logic [DATA_WIDTH-1:0] init_right_w;
    logic                  arith;
    alu_op_t               arith_op;
    alu_ctl_t              alu_ctl;
    logic [DATA_WIDTH-1:0] alu_a;
    logic [DATA_WIDTH-1:0] alu_b;
    logic                  alu_done;
    logic [DATA_WIDTH-1:0] alu_result;

    assign dec_in       = dac_decode(cmd.opcode, cmd.from_event);
    assign init_left_w  = DATA_WIDTH'(cfg.init_left);
    assign init_right_w = DATA_WIDTH'(cfg.init_right);

    // Add, multiply and divide go through the serial unit.
    always_comb
    begin
        arith    = 1'b1;
        arith_op = ALU_ADD;
        case (dec_reg.kind)
            KIND_ADD: arith_op = ALU_ADD;
            KIND_MUL: arith_op = ALU_MUL;
            KIND_DIV: arith_op = ALU_DIV;
            default:  arith = 1'b0;
        endcase
    end

    // Operands for the serial unit.
    always_comb
    begin
        alu_a = left_reg;
        alu_b = operand_reg;
        if (state_reg == C_RIGHT)
        begin
            alu_a = right_reg;
        end
        else if (state_reg == C_CMP)
        begin
            alu_b = right_reg;
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next   = state_reg;
        dec_next     = dec_reg;
        operand_next = operand_reg;
        left_next    = left_reg;
        right_next   = right_reg;
        diff_next    = diff_reg;
        kind_next    = kind_reg;
        value_next   = value_reg;
        last_next    = last_reg;
        alu_ctl      = '{start: 1'b0, op: arith_op};
        case (state_reg)
            C_IDLE:
            begin
                if (cmd.valid)
                begin
                    dec_next     = dec_in;
                    operand_next = DATA_WIDTH'(cmd.operand);
                    if (dec_in.valid)
                    begin
                        state_next = C_LEFT;
                    end
                end
            end
            C_LEFT:
            begin
                state_next = C_RIGHT;
                if (dec_reg.upd_left)
                begin
                    if (arith)
                    begin
                        alu_ctl.start = 1'b1;
                        state_next    = C_LWAIT;
                    end
                    else if (dec_reg.kind == KIND_SET)
                    begin
                        left_next = operand_reg;
                    end
                    else if (dec_reg.kind == KIND_CLEAR)
                    begin
                        left_next = '0;
                    end
                    else
                    begin
                        left_next = init_left_w;
                    end
                end
            end
            C_LWAIT:
            begin
                if (alu_done)
                begin
                    left_next  = alu_result;
                    state_next = C_RIGHT;
                end
            end
            C_RIGHT:
            begin
                state_next = C_CMP;
                if (dec_reg.upd_right)
                begin
                    if (arith)
                    begin
                        alu_ctl.start = 1'b1;
                        state_next    = C_RWAIT;
                    end
                    else if (dec_reg.kind == KIND_SET)
                    begin
                        right_next = operand_reg;
                    end
                    else if (dec_reg.kind == KIND_CLEAR)
                    begin
                        right_next = '0;
                    end
                    else
                    begin
                        right_next = init_right_w;
                    end
                end
            end
            C_RWAIT:
            begin
                if (alu_done)
                begin
                    right_next = alu_result;
                    state_next = C_CMP;
                end
            end
            C_CMP:
            begin
                if (dec_reg.cmp)
                begin
                    alu_ctl       = '{start: 1'b1, op: ALU_SUB};
                    state_next    = C_CWAIT;
                end
                else
                begin
                    state_next = C_IDLE;
                end
            end
            C_CWAIT:
            begin
                if (alu_done)
                begin
                    // First item: left when equal, else the difference.
                    diff_next = alu_result;
                    last_next = 1'b0;
                    if (alu_result == '0)
                    begin
                        kind_next  = RK_EQUAL;
                        value_next = REPORT_W'(left_reg);
                    end
                    else
                    begin
                        kind_next  = RK_NOT_EQUAL;
                        value_next = REPORT_W'(alu_result);
                    end
                    // On-compare action, on the values the difference was taken from.
                    case (cfg.action)
                        ACT_CLEAR_BOTH:
                        begin
                            left_next  = '0;
                            right_next = '0;
                        end
                        ACT_CLEAR_LEFT:    left_next  = '0;
                        ACT_CLEAR_RIGHT:   right_next = '0;
                        ACT_RESTORE_BOTH:
                        begin
                            left_next  = init_left_w;
                            right_next = init_right_w;
                        end
                        ACT_RESTORE_LEFT:  left_next  = init_left_w;
                        ACT_RESTORE_RIGHT: right_next = init_right_w;
                        ACT_COPY_L2R:      right_next = left_reg;
                        ACT_COPY_R2L:      left_next  = right_reg;
                        default:
                        begin
                        end
                    endcase
                    state_next = C_OUT1;
                end
            end
            C_OUT1:
            begin
                if (rpt.ready)
                begin
                    kind_next  = RK_COMPARED;
                    value_next = REPORT_W'(diff_reg);
                    last_next  = 1'b1;
                    state_next = C_OUT2;
                end
            end
            C_OUT2:
            begin
                if (rpt.ready)
                begin
                    state_next = C_IDLE;
                end
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    // Control state and accumulators.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            left_reg  <= '0;
            right_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            left_reg  <= left_next;
            right_reg <= right_next;
        end
    end

    // Command and report payload.
    always_ff @(posedge clk)
    begin
        dec_reg     <= dec_next;
        operand_reg <= operand_next;
        diff_reg    <= diff_next;
        kind_reg    <= kind_next;
        value_reg   <= value_next;
        last_reg    <= last_next;
    end

    dac_serial_alu #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (alu_ctl),
        .a      (alu_a),
        .b      (alu_b),
        .done   (alu_done),
        .result (alu_result)
    );

    assign cmd.ready        = (state_reg == C_IDLE);
    assign rpt.valid        = (state_reg == C_OUT1) || (state_reg == C_OUT2);
    assign rpt.report_kind  = kind_reg;
    assign rpt.report_value = value_reg;
    assign rpt.last         = last_reg;

endmodule

// File: sv/dual_accumulator_compare_unit.sv
// ----------------------------------------------------------------------------
// dual_accumulator_compare_unit
// Two signed accumulators updated by commands, with compare reports.
//
//   channel  direction  item                                   handshake
//   cfg      in         index, data (register write)           valid/ready
//   cmd      in         opcode, operand, from_event            valid/ready
//   rpt      out        report_kind, report_value, last        valid/ready
//
// One command is in flight at a time; cmd.ready is high only while idle.
// Set, clear and restore do not use the serial unit. Add, multiply and divide
// run each touched accumulator through the one-bit-per-cycle serial unit, a
// divide with extra steps to take and restore signs. A compare runs a
// subtract on the serial unit and then issues two report items, each held
// until rpt.ready. Reset clears both accumulators and restores the register
// defaults; cfg.ready is always high.
// ----------------------------------------------------------------------------
module dual_accumulator_compare_unit
    import dac_pkg::*;
#(
    parameter int DATA_WIDTH = DAC_DATA_WIDTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    dac_cfg_if.sink   cfg,
    dac_cmd_if.sink   cmd,
    dac_rpt_if.source rpt
);

    logic signed [CFG_DATA_W-1:0] init_left_reg;
    logic signed [CFG_DATA_W-1:0] init_right_reg;
    logic        [ACTION_W-1:0]   action_reg;
    cfg_t                         cfg_vals;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_left_reg  <= '0;
            init_right_reg <= '0;
            action_reg     <= ACT_NONE;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_INIT_LEFT:      init_left_reg  <= cfg.data;
                REG_INIT_RIGHT:     init_right_reg <= cfg.data;
                REG_COMPARE_ACTION: action_reg     <= cfg.data[ACTION_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg.ready           = 1'b1;
    assign cfg_vals.init_left  = init_left_reg;
    assign cfg_vals.init_right = init_right_reg;
    assign cfg_vals.action     = action_reg;

    dac_ctrl #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_vals),
        .cmd   (cmd),
        .rpt   (rpt)
    );

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench of dual_accumulator_compare_unit. A queue-fed
// driver sends accumulator commands with random gaps, the report side stalls
// at random, and a local model of both accumulators predicts every report
// item. The registers are rewritten between phases while the unit is idle.
// ----------------------------------------------------------------------------
module tb
    import dac_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DATA_W = DAC_DATA_WIDTH;

    localparam logic [DATA_W-1:0] MOST_POS = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] MOST_NEG = {1'b1, {(DATA_W-1){1'b0}}};

    // Codes outside the command set, and the register index that is not mapped.
    localparam logic [OPCODE_W-1:0]    OP_FIRST_UNUSED = OP_RESTORE_RIGHT + 1'b1;
    localparam logic [OPCODE_W-1:0]    OP_LAST_CODE    = {OPCODE_W{1'b1}};
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED      = {CFG_INDEX_W{1'b1}};

    localparam int N_PHASES      = 16;
    localparam int PHASE_ITEMS   = 110;
    localparam int HOLD_PHASE    = 5;
    localparam int RPT_LONG_HOLD = 400;
    localparam int IDLE_SETTLE   = 160;
    localparam int WATCHDOG_MAX  = 4000;
    localparam int MAX_PRINTED   = 40;

    typedef struct packed {
        logic [OPCODE_W-1:0]  opcode;
        logic [OPERAND_W-1:0] operand;
        logic                 from_event;
    } accum_cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [REPORT_W-1:0] value;
        logic                last;
    } compare_report_t;

    logic clk;
    logic rst_n;

    dac_cfg_if cfg_ch ();
    dac_cmd_if cmd_ch ();
    dac_rpt_if rpt_ch ();

    dual_accumulator_compare_unit #(
        .DATA_WIDTH (DATA_W)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .cmd   (cmd_ch),
        .rpt   (rpt_ch)
    );

    // Model state: both accumulators and the three registers.
    logic [DATA_W-1:0]     model_left     = '0;
    logic [DATA_W-1:0]     model_right    = '0;
    logic [CFG_DATA_W-1:0] model_init_l   = '0;
    logic [CFG_DATA_W-1:0] model_init_r   = '0;
    logic [ACTION_W-1:0]   model_action   = ACT_NONE;

    accum_cmd_t      cmd_pending[$];
    compare_report_t reports_due[$];
    compare_report_t due_rpt;
    accum_cmd_t      next_cmd;

    // Handshake bookkeeping; each variable is written by one process only.
    logic cmd_burst     = 1'b0;
    logic rpt_burst     = 1'b0;
    logic rpt_hold_req  = 1'b0;
    logic rpt_hold_done = 1'b0;
    logic any_accept;
    int   cmd_sent      = 0;
    int   rpt_seen      = 0;
    int   cmd_gap       = 0;
    int   rpt_stall     = 0;
    int   rpt_hold_left = 0;
    int   idle_cycles   = 0;

    int error_count  = 0;
    int n_commands   = 0;
    int n_ignored    = 0;
    int n_reports    = 0;
    int n_cfg_writes = 0;

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Print one mismatch and count it.
    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= MAX_PRINTED)
        begin
            $display("ERROR @%0t: %s", $realtime, msg);
        end
    endtask

    // One accumulator update, wrapping at the accumulator width.
    function automatic logic [DATA_W-1:0] apply_update(cmd_kind_t kind,
                                                       logic [DATA_W-1:0] acc,
                                                       logic [DATA_W-1:0] val,
                                                       logic [DATA_W-1:0] init_val);
        logic [DATA_W-1:0] mag_a;
        logic [DATA_W-1:0] mag_b;
        logic [DATA_W-1:0] quo;
        mag_a = acc[DATA_W-1] ? ~acc + 1'b1 : acc;
        mag_b = val[DATA_W-1] ? ~val + 1'b1 : val;
        case (kind)
            KIND_SET:   return val;
            KIND_ADD:   return acc + val;
            KIND_MUL:   return acc * val;
            KIND_DIV:
            begin
                // Truncating division on magnitudes; zero divisor gives zero.
                if (val == '0)
                begin
                    return '0;
                end
                quo = mag_a / mag_b;
                return (acc[DATA_W-1] ^ val[DATA_W-1]) ? ~quo + 1'b1 : quo;
            end
            KIND_CLEAR: return '0;
            default:    return init_val;
        endcase
    endfunction

    // Apply one accepted command to the model and queue its report items.
    task automatic predict_command(input logic [OPCODE_W-1:0] op,
                                   input logic [OPERAND_W-1:0] opd,
                                   input logic ev);
        cmd_kind_t         kind;
        logic              touch_l;
        logic              touch_r;
        logic              does_cmp;
        logic [DATA_W-1:0] snap_l;
        logic [DATA_W-1:0] snap_r;
        logic [DATA_W-1:0] diff;
        compare_report_t   rpt_item;
        touch_l  = 1'b0;
        touch_r  = 1'b0;
        does_cmp = 1'b0;
        if (!ev || op > OP_RESTORE_RIGHT)
        begin
            n_ignored++;
            return;
        end
        case (op)
            OP_ADD_BOTH, OP_ADD_LEFT, OP_ADD_RIGHT, OP_ADD_LEFT_CMP, OP_ADD_RIGHT_CMP:
                kind = KIND_ADD;
            OP_MUL_BOTH, OP_MUL_LEFT, OP_MUL_RIGHT, OP_MUL_LEFT_CMP, OP_MUL_RIGHT_CMP:
                kind = KIND_MUL;
            OP_DIV_BOTH, OP_DIV_LEFT, OP_DIV_RIGHT, OP_DIV_LEFT_CMP, OP_DIV_RIGHT_CMP:
                kind = KIND_DIV;
            OP_CLEAR_BOTH, OP_CLEAR_LEFT, OP_CLEAR_RIGHT:
                kind = KIND_CLEAR;
            OP_RESTORE_BOTH, OP_RESTORE_LEFT, OP_RESTORE_RIGHT:
                kind = KIND_RESTORE;
            default:
                kind = KIND_SET;
        endcase
        case (op)
            OP_SET_BOTH, OP_ADD_BOTH, OP_MUL_BOTH, OP_DIV_BOTH, OP_CLEAR_BOTH,
            OP_RESTORE_BOTH:
            begin
                touch_l = 1'b1;
                touch_r = 1'b1;
            end
            OP_SET_LEFT, OP_SET_LEFT_CMP, OP_ADD_LEFT, OP_ADD_LEFT_CMP, OP_MUL_LEFT,
            OP_MUL_LEFT_CMP, OP_DIV_LEFT, OP_DIV_LEFT_CMP, OP_CLEAR_LEFT, OP_RESTORE_LEFT:
                touch_l = 1'b1;
            OP_SET_RIGHT, OP_SET_RIGHT_CMP, OP_ADD_RIGHT, OP_ADD_RIGHT_CMP, OP_MUL_RIGHT,
            OP_MUL_RIGHT_CMP, OP_DIV_RIGHT, OP_DIV_RIGHT_CMP, OP_CLEAR_RIGHT,
            OP_RESTORE_RIGHT:
                touch_r = 1'b1;
            default: ;
        endcase
        case (op)
            OP_COMPARE, OP_SET_LEFT_CMP, OP_SET_RIGHT_CMP, OP_ADD_LEFT_CMP,
            OP_ADD_RIGHT_CMP, OP_MUL_LEFT_CMP, OP_MUL_RIGHT_CMP, OP_DIV_LEFT_CMP,
            OP_DIV_RIGHT_CMP:
                does_cmp = 1'b1;
            default: ;
        endcase

        if (touch_l)
        begin
            model_left = apply_update(kind, model_left, opd, model_init_l);
        end
        if (touch_r)
        begin
            model_right = apply_update(kind, model_right, opd, model_init_r);
        end
        if (!does_cmp)
        begin
            return;
        end

        // The difference is taken before the on-compare action changes anything.
        snap_l = model_left;
        snap_r = model_right;
        diff   = snap_l - snap_r;
        case (model_action)
            ACT_CLEAR_BOTH:
            begin
                model_left  = '0;
                model_right = '0;
            end
            ACT_CLEAR_LEFT:    model_left  = '0;
            ACT_CLEAR_RIGHT:   model_right = '0;
            ACT_RESTORE_BOTH:
            begin
                model_left  = model_init_l;
                model_right = model_init_r;
            end
            ACT_RESTORE_LEFT:  model_left  = model_init_l;
            ACT_RESTORE_RIGHT: model_right = model_init_r;
            ACT_COPY_L2R:      model_right = model_left;
            ACT_COPY_R2L:      model_left  = model_right;
            default: ;
        endcase

        rpt_item.kind  = (diff == '0) ? RK_EQUAL : RK_NOT_EQUAL;
        rpt_item.value = (diff == '0) ? snap_l : diff;
        rpt_item.last  = 1'b0;
        reports_due.push_back(rpt_item);
        rpt_item.kind  = RK_COMPARED;
        rpt_item.value = diff;
        rpt_item.last  = 1'b1;
        reports_due.push_back(rpt_item);
    endtask

    // Operand mix: extremes, small values that make equal compares likely, full range.
    function automatic logic [OPERAND_W-1:0] pick_operand();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
        begin
            case ($urandom_range(0, 4))
                0:       return '0;
                1:       return 1;
                2:       return '1;
                3:       return MOST_POS;
                default: return MOST_NEG;
            endcase
        end
        else if (sel < 5)
        begin
            return $urandom_range(0, 32) - 16;
        end
        return $urandom();
    endfunction

    function automatic logic [OPCODE_W-1:0] pick_compare_op();
        case ($urandom_range(0, 8))
            0:       return OP_COMPARE;
            1:       return OP_SET_LEFT_CMP;
            2:       return OP_SET_RIGHT_CMP;
            3:       return OP_ADD_LEFT_CMP;
            4:       return OP_ADD_RIGHT_CMP;
            5:       return OP_MUL_LEFT_CMP;
            6:       return OP_MUL_RIGHT_CMP;
            7:       return OP_DIV_LEFT_CMP;
            default: return OP_DIV_RIGHT_CMP;
        endcase
    endfunction

    task automatic push_cmd(input logic [OPCODE_W-1:0] op, input logic [OPERAND_W-1:0] opd,
                            input logic ev);
        accum_cmd_t c;
        c.opcode     = op;
        c.operand    = opd;
        c.from_event = ev;
        cmd_pending.push_back(c);
    endtask

    // Queue random commands until the given number of live ones is reached.
    task automatic push_random(input int live_count);
        int          live;
        int unsigned sel;
        accum_cmd_t  c;
        live = 0;
        while (live < live_count)
        begin
            sel          = $urandom_range(0, 99);
            c.operand    = pick_operand();
            c.from_event = 1'b1;
            if (sel < 5)
            begin
                c.opcode     = OPCODE_W'($urandom_range(0, OP_LAST_CODE));
                c.from_event = 1'b0;
            end
            else if (sel < 9)
            begin
                c.opcode = OPCODE_W'($urandom_range(OP_FIRST_UNUSED, OP_LAST_CODE));
            end
            else if (sel < 35)
            begin
                c.opcode = pick_compare_op();
            end
            else
            begin
                c.opcode = OPCODE_W'($urandom_range(OP_COMPARE, OP_RESTORE_RIGHT));
            end
            cmd_pending.push_back(c);
            if (c.from_event && c.opcode <= OP_RESTORE_RIGHT)
            begin
                live++;
            end
        end
    endtask

    // Wait until every queued command is sent and every report item has come.
    task automatic wait_all_done();
        do
            @(posedge clk);
        while (cmd_pending.size() != 0 || cmd_ch.valid || reports_due.size() != 0);
    endtask

    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        cfg_ch.valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Command driver: holds an item until accepted, then waits its drawn gap.
    // The item on the channel is taken once the accepted count catches up.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            cmd_ch.valid      <= 1'b0;
            cmd_ch.opcode     <= OP_COMPARE;
            cmd_ch.operand    <= '0;
            cmd_ch.from_event <= 1'b0;
        end
        else if (n_commands == cmd_sent)
        begin
            if (cmd_gap > 0)
            begin
                cmd_gap--;
                cmd_ch.valid <= 1'b0;
            end
            else if (cmd_pending.size() > 0)
            begin
                next_cmd = cmd_pending.pop_front();
                cmd_ch.opcode     <= next_cmd.opcode;
                cmd_ch.operand    <= next_cmd.operand;
                cmd_ch.from_event <= next_cmd.from_event;
                cmd_ch.valid      <= 1'b1;
                cmd_sent++;
                if ($urandom_range(0, 39) == 0)
                begin
                    cmd_burst = !cmd_burst;
                end
                cmd_gap = cmd_burst ? 0 : $urandom_range(0, 14);
            end
            else
            begin
                cmd_ch.valid <= 1'b0;
            end
        end
    end

    // Report receiver: random stall per item, plus one long hold on request.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            rpt_ch.ready <= 1'b0;
        end
        else
        begin
            if (rpt_hold_req && !rpt_hold_done)
            begin
                rpt_hold_left = RPT_LONG_HOLD;
                rpt_hold_done = 1'b1;
            end
            if (n_reports != rpt_seen)
            begin
                rpt_seen = n_reports;
                if ($urandom_range(0, 29) == 0)
                begin
                    rpt_burst = !rpt_burst;
                end
                rpt_stall = rpt_burst ? 0 : $urandom_range(0, 14);
            end
            if (rpt_hold_left > 0)
            begin
                rpt_hold_left--;
                rpt_ch.ready <= 1'b0;
            end
            else if (rpt_stall > 0)
            begin
                rpt_stall--;
                rpt_ch.ready <= 1'b0;
            end
            else
            begin
                rpt_ch.ready <= 1'b1;
            end
        end
    end

    // Monitor: register writes, command prediction, report checking, watchdog.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            any_accept = 1'b0;
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                any_accept = 1'b1;
                n_cfg_writes++;
                case (cfg_ch.index)
                    REG_INIT_LEFT:      model_init_l = cfg_ch.data;
                    REG_INIT_RIGHT:     model_init_r = cfg_ch.data;
                    REG_COMPARE_ACTION: model_action = cfg_ch.data[ACTION_W-1:0];
                    default: ;
                endcase
            end
            if (rpt_ch.valid && rpt_ch.ready)
            begin
                any_accept = 1'b1;
                n_reports++;
                if (reports_due.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected report: kind %0d value %h last %0b",
                                              rpt_ch.report_kind, rpt_ch.report_value,
                                              rpt_ch.last));
                end
                else
                begin
                    due_rpt = reports_due.pop_front();
                    if (rpt_ch.report_kind !== due_rpt.kind
                        || rpt_ch.report_value !== due_rpt.value
                        || rpt_ch.last !== due_rpt.last)
                    begin
                        report_mismatch($sformatf(
                            "report %0d: got kind %0d value %h last %0b, want %0d %h %0b",
                            n_reports, rpt_ch.report_kind, rpt_ch.report_value,
                            rpt_ch.last, due_rpt.kind, due_rpt.value, due_rpt.last));
                    end
                end
            end
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                any_accept = 1'b1;
                n_commands++;
                predict_command(cmd_ch.opcode, cmd_ch.operand, cmd_ch.from_event);
            end
            idle_cycles = any_accept ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_MAX)
            begin
                $display("ERROR: no handshake for %0d cycles, %0d report items outstanding",
                         WATCHDOG_MAX, reports_due.size());
                $display("FAIL dual_accumulator_compare_unit");
                $finish;
            end
        end
    end

    // Stimulus and end of run.
    initial
    begin
        logic [CFG_DATA_W-1:0] init_l;
        logic [CFG_DATA_W-1:0] init_r;
        int                    phase;

        rst_n             = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = REG_INIT_LEFT;
        cfg_ch.data       = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: extremes, wrap, divide overflow and by zero, truncation,
        // clear and restore at reset values, and ignored commands.
        push_cmd(OP_SET_BOTH,      MOST_POS, 1'b1);
        push_cmd(OP_COMPARE,       '0,       1'b1);
        push_cmd(OP_ADD_LEFT_CMP,  1,        1'b1);
        push_cmd(OP_SET_LEFT,      MOST_NEG, 1'b1);
        push_cmd(OP_DIV_LEFT_CMP,  '1,       1'b1);
        push_cmd(OP_DIV_RIGHT_CMP, '0,       1'b1);
        push_cmd(OP_SET_RIGHT_CMP, -7,       1'b1);
        push_cmd(OP_MUL_BOTH,      '1,       1'b1);
        push_cmd(OP_MUL_LEFT_CMP,  32'h0001_0000, 1'b1);
        push_cmd(OP_ADD_BOTH,      '1,       1'b1);
        push_cmd(OP_ADD_RIGHT,     5,        1'b1);
        push_cmd(OP_ADD_RIGHT_CMP, MOST_POS, 1'b1);
        push_cmd(OP_MUL_RIGHT,     3,        1'b1);
        push_cmd(OP_MUL_RIGHT_CMP, MOST_NEG, 1'b1);
        push_cmd(OP_SET_BOTH,      -100,     1'b1);
        push_cmd(OP_DIV_BOTH,      7,        1'b1);
        push_cmd(OP_DIV_LEFT,      3,        1'b1);
        push_cmd(OP_DIV_RIGHT,     -4,       1'b1);
        push_cmd(OP_SET_LEFT_CMP,  3,        1'b1);
        push_cmd(OP_FIRST_UNUSED,  MOST_POS, 1'b1);
        push_cmd(OP_LAST_CODE,     MOST_NEG, 1'b1);
        push_cmd(OP_COMPARE,       '0,       1'b0);
        push_cmd(OP_SET_BOTH,      MOST_POS, 1'b0);
        push_cmd(OP_CLEAR_LEFT,    '1,       1'b1);
        push_cmd(OP_CLEAR_RIGHT,   '1,       1'b1);
        push_cmd(OP_RESTORE_LEFT,  '1,       1'b1);
        push_cmd(OP_RESTORE_RIGHT, '1,       1'b1);
        push_cmd(OP_CLEAR_BOTH,    '1,       1'b1);
        push_cmd(OP_COMPARE,       '0,       1'b1);

        // Random phases, one on-compare action each, undefined codes included.
        for (phase = 0; phase < N_PHASES; phase++)
        begin
            wait_all_done();
            repeat (IDLE_SETTLE) @(posedge clk);
            case (phase)
                0:
                begin
                    init_l = MOST_NEG;
                    init_r = MOST_POS;
                end
                1:
                begin
                    init_l = MOST_POS;
                    init_r = MOST_NEG;
                end
                2:
                begin
                    init_l = '0;
                    init_r = '0;
                end
                default:
                begin
                    init_l = pick_operand();
                    init_r = ($urandom_range(0, 3) == 0) ? init_l : pick_operand();
                end
            endcase
            cfg_write(REG_INIT_LEFT, init_l);
            cfg_write(REG_INIT_RIGHT, init_r);
            cfg_write(REG_COMPARE_ACTION, ($urandom() & ~32'hF) | phase);
            if (phase == 7)
            begin
                cfg_write(REG_UNUSED, $urandom());
            end

            push_random(PHASE_ITEMS / 2);
            if (phase == HOLD_PHASE)
            begin
                // Stall the report side long enough that the unit backs up.
                @(posedge clk);
                rpt_hold_req = 1'b1;
            end
            // Sender pauses here until every report item is back.
            wait_all_done();
            push_random(PHASE_ITEMS - PHASE_ITEMS / 2);
        end

        wait_all_done();
        repeat (IDLE_SETTLE) @(posedge clk);
        if (reports_due.size() != 0)
        begin
            report_mismatch($sformatf("%0d report items never arrived", reports_due.size()));
        end

        $display("Run covered %0d commands (%0d ignored) and %0d report items,",
                 n_commands, n_ignored, n_reports);
        $display("with %0d register writes over %0d compare actions; %0d mismatches.",
                 n_cfg_writes, N_PHASES, error_count);
        if (error_count == 0)
        begin
            $display("PASS dual_accumulator_compare_unit");
        end
        else
        begin
            $display("FAIL dual_accumulator_compare_unit");
        end
        $finish;
    end

endmodule
